// ===== hw/rtl/cpn_pkg.sv =====
// ----------------------------------------------------------------------------
// cpn_pkg
// Shared widths, beat types and the output packing function of the
// normalized cross product pipeline.
// ----------------------------------------------------------------------------
package cpn_pkg;

    localparam int OUT_W    = 34;
    localparam int OUT_FRAC = 16;
    localparam int M_W      = 31;   // component magnitude after range shift
    localparam int SH_W     = 5;    // range shift amount
    localparam int SUM_W    = 64;   // sum of squares and root work width
    localparam int N_W      = 32;   // vector length
    localparam int REM_W    = 48;   // divider remainder
    localparam int Q_W      = 17;   // quotient, at most 2^16
    localparam int ROOT_STEPS = 32;

    // beat moving down the square root chain
    typedef struct packed {
        logic                        valid;
        logic                        norm;
        logic [2:0]                  neg;
        logic [2:0][M_W-1:0]         m;
        logic [2:0][OUT_W-1:0]       raw;
        logic [SUM_W-1:0]            rem;
        logic [SUM_W-1:0]            root;
    } t_sq_beat;

    // beat moving down the divider chain
    typedef struct packed {
        logic                        valid;
        logic                        norm;
        logic                        zero;
        logic [2:0]                  neg;
        logic [2:0][OUT_W-1:0]       raw;
        logic [N_W-1:0]              n;
        logic [2:0][REM_W-1:0]       rem;
        logic [2:0][Q_W-1:0]         q;
    } t_dv_beat;

    // saturate a sign and magnitude into a signed Q18.16 (34-bit) word
    function automatic logic [OUT_W-1:0] pack_out(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m2;
        lim = neg ? (64'(1) << (OUT_W - 1)) : ((64'(1) << (OUT_W - 1)) - 64'(1));
        m2  = (mag > lim) ? lim : mag;
        return neg ? OUT_W'(64'(0) - m2) : OUT_W'(m2);
    endfunction

endpackage

// ===== hw/rtl/cpn_if.sv =====
// ----------------------------------------------------------------------------
// cpn_in_if / cpn_out_if
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface cpn_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic                normalize;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, normalize, input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, normalize, output ready);
endinterface

interface cpn_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [33:0]   res_x;
    logic signed [33:0]   res_y;
    logic signed [33:0]   res_z;
    logic                 zero_length;

    modport source (output valid, res_x, res_y, res_z, zero_length, input ready);
    modport sink   (input valid, res_x, res_y, res_z, zero_length, output ready);
endinterface

// ===== hw/rtl/cross_product_normalized.sv =====
// ----------------------------------------------------------------------------
// cross_product_normalized
// 3D cross product of two signed fixed-point vectors, optionally divided by
// its floor-root length, giving signed Q18.16 (34-bit) components.
// ----------------------------------------------------------------------------
// The block takes one operand beat per clock and returns one result beat per
// operand, in order, through six front-end stages (products, cross terms,
// range shift, squares, sum), a chain of 32 square root cells that settle
// one root bit each, 17 divider cells that settle one quotient bit of all
// three components each, and the output register. The whole chain advances
// together and holds while a result waits unread.
// A zero-length product with normalize set returns zeros and zero_length.
module cross_product_normalized
    import cpn_pkg::*;
#(
    parameter int IN_WIDTH     = 16,
    parameter int IN_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpn_in_if.sink      i_in,
    cpn_out_if.source   o_out
);

    logic     en;
    t_sq_beat sq [ROOT_STEPS+1];
    t_dv_beat dv [Q_W+1];
    logic     r_valid;
    logic [OUT_W-1:0] r_x, r_y, r_z;
    logic     r_zero;
    logic [2:0][OUT_W-1:0] n_res;
    logic     n_zero;

    // advance the chain unless a result is stalled
    assign en         = !r_valid || o_out.ready;
    assign i_in.ready = en;

    cpn_front #(
        .IN_WIDTH     (IN_WIDTH),
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in.valid),
        .i_a_x       (i_in.a_x),
        .i_a_y       (i_in.a_y),
        .i_a_z       (i_in.a_z),
        .i_b_x       (i_in.b_x),
        .i_b_y       (i_in.b_y),
        .i_b_z       (i_in.b_z),
        .i_normalize (i_in.normalize),
        .o_beat      (sq[0])
    );

    // square root chain, most significant digit first
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
        cpn_sqrt_cell #(.K(ROOT_STEPS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_beat  (sq[k]),
            .o_beat  (sq[k+1])
        );
    end

    // load the dividers from the finished root
    always_comb begin
        dv[0].valid = sq[ROOT_STEPS].valid;
        dv[0].norm  = sq[ROOT_STEPS].norm;
        dv[0].zero  = (sq[ROOT_STEPS].root == '0);
        dv[0].neg   = sq[ROOT_STEPS].neg;
        dv[0].raw   = sq[ROOT_STEPS].raw;
        dv[0].n     = sq[ROOT_STEPS].root[N_W-1:0];
        dv[0].q     = '0;
        for (int i = 0; i < 3; i++) begin
            dv[0].rem[i] = REM_W'({sq[ROOT_STEPS].m[i], OUT_FRAC'(0)});
        end
    end

    // divider chain, top quotient bit first
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        cpn_div_cell #(.J(Q_W - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_beat  (dv[j]),
            .o_beat  (dv[j+1])
        );
    end

    // select raw, normalized or zero-length result
    always_comb begin
        n_zero = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!dv[Q_W].norm) begin
                n_res[i] = dv[Q_W].raw[i];
            end else if (dv[Q_W].zero) begin
                n_res[i] = '0;
            end else begin
                n_res[i] = pack_out(dv[Q_W].neg[i], 64'(dv[Q_W].q[i]));
            end
        end
        n_zero = dv[Q_W].norm && dv[Q_W].zero;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= dv[Q_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x    <= n_res[0];
            r_y    <= n_res[1];
            r_z    <= n_res[2];
            r_zero <= n_zero;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.res_x       = r_x;
    assign o_out.res_y       = r_y;
    assign o_out.res_z       = r_z;
    assign o_out.zero_length = r_zero;

endmodule

// ===== hw/rtl/cpn_front.sv =====
// ----------------------------------------------------------------------------
// cpn_front
// Six-stage front end: products, cross terms, range shift, raw Q18.16 form,
// squares and their sum, handed to the square root chain.
// ----------------------------------------------------------------------------
module cpn_front
    import cpn_pkg::*;
#(
    parameter int IN_WIDTH     = 16,
    parameter int IN_FRAC_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [IN_WIDTH-1:0] i_a_x,
    input  logic signed [IN_WIDTH-1:0] i_a_y,
    input  logic signed [IN_WIDTH-1:0] i_a_z,
    input  logic signed [IN_WIDTH-1:0] i_b_x,
    input  logic signed [IN_WIDTH-1:0] i_b_y,
    input  logic signed [IN_WIDTH-1:0] i_b_z,
    input  logic                       i_normalize,
    output t_sq_beat                   o_beat
);

    localparam int PW  = 2 * IN_WIDTH;
    localparam int CW  = PW + 1;
    localparam int UP  = OUT_FRAC - 2 * IN_FRAC_BITS;
    localparam int SHL = (UP >= 0) ? UP : 0;
    localparam int SHR = (UP < 0) ? -UP : 0;
    localparam logic [63:0] CAP = 64'(1) << OUT_W;

    logic [4:0]                    r_vld;
    logic [4:0]                    r_nm;
    logic signed [5:0][PW-1:0]     r_p;
    logic [2:0][PW-1:0]            r_mag2, r_mag3;
    logic [2:0]                    r_neg2, r_neg3, r_neg4, r_neg5;
    logic [SH_W-1:0]               r_sh;
    logic [2:0][OUT_W-1:0]         r_raw3, r_raw4, r_raw5;
    logic [2:0][M_W-1:0]           r_m4, r_m5;
    logic [2:0][2*M_W-1:0]         r_sq5;

    logic signed [2:0][CW-1:0]     c;
    logic [2:0][CW-1:0]            c_abs;
    logic [PW-1:0]                 mag_or;
    logic [SH_W-1:0]               sh;
    logic [2:0][63:0]              up_mag;
    logic [2:0][OUT_W-1:0]         raw;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            o_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_vld        <= {r_vld[3:0], i_valid};
            o_beat.valid <= r_vld[4];
        end
    end

    // cross terms, sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c[i]     = CW'($signed(r_p[2*i])) - CW'($signed(r_p[2*i+1]));
            c_abs[i] = c[i][CW-1] ? CW'(-c[i]) : CW'(c[i]);
        end
    end

    // range shift so every magnitude drops below 2^31; raw Q18.16 form
    always_comb begin
        mag_or = r_mag2[0] | r_mag2[1] | r_mag2[2];
        sh     = '0;
        for (int b = 0; b < PW; b++) begin
            if (mag_or[b] && b >= M_W) begin
                sh = SH_W'(b - M_W + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            up_mag[i] = 64'(r_mag2[i]);
            if (UP >= 0 && up_mag[i] > (CAP >> SHL)) begin
                up_mag[i] = CAP;
            end else begin
                up_mag[i] = (up_mag[i] << SHL) >> SHR;
            end
            raw[i] = pack_out(r_neg2[i], up_mag[i]);
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_a_y * i_b_z;
            r_p[1] <= i_a_z * i_b_y;
            r_p[2] <= i_a_z * i_b_x;
            r_p[3] <= i_b_z * i_a_x;
            r_p[4] <= i_a_x * i_b_y;
            r_p[5] <= i_a_y * i_b_x;
            r_nm   <= {r_nm[3:0], i_normalize};
            for (int i = 0; i < 3; i++) begin
                r_mag2[i] <= c_abs[i][PW-1:0];
                r_neg2[i] <= c[i][CW-1];
                r_m4[i]   <= M_W'(64'(r_mag3[i]) >> r_sh);
                r_sq5[i]  <= r_m4[i] * r_m4[i];
            end
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
            r_sh   <= sh;
            r_raw3 <= raw;
            r_neg4 <= r_neg3;
            r_raw4 <= r_raw3;
            r_neg5 <= r_neg4;
            r_raw5 <= r_raw4;
            r_m5   <= r_m4;
            o_beat.norm <= r_nm[4];
            o_beat.neg  <= r_neg5;
            o_beat.m    <= r_m5;
            o_beat.raw  <= r_raw5;
            o_beat.rem  <= SUM_W'(r_sq5[0]) + SUM_W'(r_sq5[1]) + SUM_W'(r_sq5[2]);
            o_beat.root <= '0;
        end
    end

endmodule

// ===== hw/rtl/cpn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// cpn_sqrt_cell
// One digit of the integer square root: trial subtract of root + 4^K.
// ----------------------------------------------------------------------------
module cpn_sqrt_cell
    import cpn_pkg::*;
#(
    parameter int K = 31
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_sq_beat i_beat,
    output t_sq_beat o_beat
);

    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * K);

    logic [SUM_W-1:0] trial;
    logic             ge;
    t_sq_beat         n_beat;

    // try to take this digit
    always_comb begin
        trial  = i_beat.root + BIT;
        ge     = i_beat.rem >= trial;
        n_beat = i_beat;
        if (ge) begin
            n_beat.rem  = i_beat.rem - trial;
            n_beat.root = (i_beat.root >> 1) + BIT;
        end else begin
            n_beat.root = i_beat.root >> 1;
        end
    end

    // hand to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_beat.valid <= 1'b0;
        end else if (i_en) begin
            o_beat <= n_beat;
        end
    end

endmodule

// ===== hw/rtl/cpn_div_cell.sv =====
// ----------------------------------------------------------------------------
// cpn_div_cell
// One quotient bit of three restoring divisions by the shared length.
// ----------------------------------------------------------------------------
module cpn_div_cell
    import cpn_pkg::*;
#(
    parameter int J = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_dv_beat i_beat,
    output t_dv_beat o_beat
);

    logic [REM_W-1:0] dsh;
    t_dv_beat         n_beat;

    // compare each lane against the divisor weighted by 2^J
    always_comb begin
        dsh    = REM_W'(i_beat.n) << J;
        n_beat = i_beat;
        for (int i = 0; i < 3; i++) begin
            if (i_beat.rem[i] >= dsh) begin
                n_beat.rem[i]  = i_beat.rem[i] - dsh;
                n_beat.q[i][J] = 1'b1;
            end else begin
                n_beat.q[i][J] = 1'b0;
            end
        end
    end

    // hand to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_beat.valid <= 1'b0;
        end else if (i_en) begin
            o_beat <= n_beat;
        end
    end

endmodule

// ===== tb/sv/cross_product_normalized_test.sv =====
// ----------------------------------------------------------------------------
// cross_product_normalized_test
// Drives operand beats with random gaps, predicts each cross product and its
// normalized form, and checks result beats in order under random stalls.
// ----------------------------------------------------------------------------
module cross_product_normalized_test;
    import cpn_pkg::*;

    localparam int IN_W = 16;
    localparam int LATENCY = 56;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    zero;
    } t_vec_out;

    logic i_clk;
    logic i_rst_n;
    longint cycle_cnt;
    int     err_cnt;
    bit     stim_done;
    t_vec_out expected_vecs[$];

    cpn_in_if #(.W(IN_W)) op_ch();
    cpn_out_if            res_ch();

    cross_product_normalized #(.IN_WIDTH(IN_W), .IN_FRAC_BITS(8)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch.sink),
        .o_out   (res_ch.source)
    );

    // clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // saturate sign and magnitude into Q18.16
    function automatic logic [OUT_W-1:0] sat_q16(bit neg, logic [63:0] mag);
        logic [63:0] lim;
        lim = neg ? (64'd1 << (OUT_W - 1)) : ((64'd1 << (OUT_W - 1)) - 1);
        if (mag > lim) mag = lim;
        return neg ? OUT_W'(-mag) : OUT_W'(mag);
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // compute the expected cross product beat
    function automatic t_vec_out cross_predict(logic signed [IN_W-1:0] ax, ay, az, bx, by, bz,
                                               bit norm);
        longint c[3];
        bit neg[3];
        logic [63:0] mag[3], m[3], sum, len;
        logic [OUT_W-1:0] o[3];
        int s;
        t_vec_out r;
        c[0] = longint'(ay) * bz - longint'(az) * by;
        c[1] = longint'(az) * bx - longint'(bz) * ax;
        c[2] = longint'(ax) * by - longint'(ay) * bx;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            mag[i] = neg[i] ? -c[i] : c[i];
        end
        r.zero = 1'b0;
        if (!norm) begin
            // product is already on the Q18.16 scale
            for (int i = 0; i < 3; i++) o[i] = sat_q16(neg[i], mag[i]);
        end else begin
            s = 0;
            while (s < 63 && ((mag[0] >> s) >= (64'd1 << 31) ||
                              (mag[1] >> s) >= (64'd1 << 31) ||
                              (mag[2] >> s) >= (64'd1 << 31))) s++;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = mag[i] >> s;
                sum += m[i] * m[i];
            end
            len = floor_root(sum);
            if (len == 0) begin
                for (int i = 0; i < 3; i++) o[i] = '0;
                r.zero = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) o[i] = sat_q16(neg[i], (m[i] << OUT_FRAC) / len);
            end
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        return r;
    endfunction

    task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // send one operand beat after a random gap; valid drops only during a gap
    task automatic send_vecs(logic [IN_W-1:0] ax, ay, az, bx, by, bz, bit norm);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid     <= 1'b1;
        op_ch.a_x       <= ax;
        op_ch.a_y       <= ay;
        op_ch.a_z       <= az;
        op_ch.b_x       <= bx;
        op_ch.b_y       <= by;
        op_ch.b_z       <= bz;
        op_ch.normalize <= norm;
        expected_vecs.push_back(cross_predict(ax, ay, az, bx, by, bz, norm));
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    // random sink stalls, with some stretches of no stalling
    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // check each accepted result beat
    always @(posedge i_clk) begin
        t_vec_out w;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_vecs.size() == 0) begin
                $display("unexpected result beat at cycle %0d", cycle_cnt);
                err_cnt++;
            end else begin
                w = expected_vecs.pop_front();
                if (res_ch.res_x !== w.x) report("res_x", res_ch.res_x, w.x);
                if (res_ch.res_y !== w.y) report("res_y", res_ch.res_y, w.y);
                if (res_ch.res_z !== w.z) report("res_z", res_ch.res_z, w.z);
                if (res_ch.zero_length !== w.zero)
                    report("zero_length", res_ch.zero_length, w.zero);
            end
        end
    end

    task automatic test_extremes();
        logic [IN_W-1:0] mn, mx;
        mn = 16'h8000;
        mx = 16'h7fff;
        for (int n = 0; n < 2; n++) begin
            send_vecs(0, 0, 0, 0, 0, 0, n);
            send_vecs(mn, mn, mn, mx, mx, mx, n);
            send_vecs(mn, mx, mn, mx, mn, mx, n);
            send_vecs(mn, 0, 0, 0, mn, 0, n);
            send_vecs(mn, mn, mn, mn, mn, mn, n);
            send_vecs(16'h0100, 0, 0, 0, 16'h0100, 0, n);
            send_vecs(16'hffff, 16'hffff, 0, 16'h0001, 16'hffff, 0, n);
            send_vecs(16'h0001, 16'h0002, 16'h0003, 16'h0002, 16'h0004, 16'h0006, n);
            send_vecs(mx, 16'h0001, mn, 16'hffff, mx, 16'h0001, n);
        end
    endtask

    task automatic test_random(int count);
        logic [IN_W-1:0] v[6];
        int k;
        for (int i = 0; i < count; i++) begin
            for (int j = 0; j < 6; j++) begin
                case ($urandom_range(0, 5))
                    0:       v[j] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    1:       v[j] = $urandom_range(0, 7) - 4;
                    default: v[j] = $urandom;
                endcase
            end
            // some parallel pairs for zero-length products
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(-2, 2);
                for (int j = 0; j < 3; j++) v[j + 3] = v[j] * k;
            end
            send_vecs(v[0], v[1], v[2], v[3], v[4], v[5], $urandom_range(0, 1));
        end
    endtask

    initial begin
        int wait_cnt;
        cycle_cnt = 0;
        err_cnt   = 0;
        i_rst_n <= 1'b0;
        op_ch.valid <= 1'b0;
        op_ch.a_x <= '0; op_ch.a_y <= '0; op_ch.a_z <= '0;
        op_ch.b_x <= '0; op_ch.b_y <= '0; op_ch.b_z <= '0;
        op_ch.normalize <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(1430);
        op_ch.valid <= 1'b0;
        // drain, then allow for any stray beats
        while (expected_vecs.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
